[sv/ieil_pkg.sv]
`timescale 1ns / 1ps

package ieil_pkg;

   // Request codes
   typedef enum logic [2:0] {
      OP_APPEND = 3'd0,
      OP_DROP   = 3'd1,
      OP_INSERT = 3'd2,
      OP_ERASE  = 3'd3,
      OP_READ   = 3'd4,
      OP_WRITE  = 3'd5,
      OP_CLEAR  = 3'd6,
      OP_RESIZE = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   // What every cell does on one edge
   typedef enum logic [2:0] {
      ACT_HOLD,
      ACT_INSERT,
      ACT_ERASE,
      ACT_WRITE,
      ACT_FILL
   } act_type;

   typedef enum logic [1:0] {
      S_RUN,
      S_SWEEP
   } state_type;

   typedef struct packed {
      op_type      req_type;
      logic [6:0]  position;
      logic [63:0] word_in;
   } req_item_type;

   typedef struct packed {
      logic [63:0] word_out;
      status_type  status;
      logic [6:0]  length;
      logic        is_empty;
   } rsp_item_type;

   // Broadcast to the cell row
   typedef struct packed {
      act_type     action;
      logic [6:0]  pos;
      logic [63:0] word;
   } cmd_type;

endpackage

[sv/ieil_cell.sv]
`timescale 1ns / 1ps

module ieil_cell #(
   parameter int DEPTH = 64,
   parameter int INDEX = 0
) (
   input  logic                         clock,
   input  ieil_pkg::cmd_type            cmd,
   input  logic [$clog2(DEPTH+1)-1:0]   cnt,
   input  logic [$clog2(DEPTH+1)-1:0]   fill_lim,
   input  logic [6:0]                   rd_pos,
   input  logic [63:0]                  word_left,
   input  logic [63:0]                  word_right,
   input  logic [63:0]                  col_right,
   output logic [63:0]                  word_q,
   output logic [63:0]                  col_q
);
   import ieil_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > 7) ? CW : 7;
   localparam logic [XW-1:0] IDX = XW'(INDEX);

   logic [63:0]   word_ff, word_in;
   logic [63:0]   col_ff, col_in;
   logic [XW-1:0] pos_x, rd_x, cnt_x, lim_x;

   assign pos_x = XW'(cmd.pos);
   assign rd_x  = XW'(rd_pos);
   assign cnt_x = XW'(cnt);
   assign lim_x = XW'(fill_lim);

   always_comb begin
      word_in = word_ff;
      case (cmd.action)
         ACT_INSERT: begin
            if (IDX == pos_x)     word_in = cmd.word;
            else if (IDX > pos_x) word_in = word_left;
         end
         ACT_ERASE: begin
            if (IDX >= pos_x) word_in = word_right;
         end
         ACT_WRITE: begin
            if (IDX == pos_x) word_in = cmd.word;
         end
         ACT_FILL: begin
            if (IDX >= cnt_x && IDX < lim_x) word_in = cmd.word;
         end
         default: word_in = word_ff;
      endcase
   end

   // read collector: the addressed word walks one cell a cycle towards cell 0
   assign col_in = (IDX == rd_x) ? word_ff : col_right;

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      col_ff  <= col_in;
   end

   assign word_q = word_ff;
   assign col_q  = col_ff;

endmodule

[sv/indexed_insert_erase_list_unit.sv]
`timescale 1ns / 1ps

// Ordered list of up to DEPTH 64-bit words held in a row of cells.
// Request channel (req_valid/req_ready/req_data) carries one item: a code
// (append, drop last, insert, erase, read, write, clear, resize with fill),
// a position and a word. The response channel (rsp_valid/rsp_ready/rsp_data)
// returns one item per request: word read, status, new length, empty flag.
// The response to every request but a successful read is registered in the
// cycle after it is taken; a successful read's word is collected along the
// cell row, one cell a cycle. One request per cycle while responses are taken;
// a read holds the request side until its word has been collected.
// Inserts and erases shift the cells from the position upward in parallel.
// Reset clears the count and the response valid flag; stored words are not
// cleared and only words below the count can ever be read.
// A stalled response holds in the output register and the request side stops
// taking items until it has gone.
module indexed_insert_erase_list_unit #(
   parameter int DEPTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ieil_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ieil_pkg::rsp_item_type rsp_data
);
   import ieil_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > 7) ? CW : 7;
   localparam int SW = $clog2(DEPTH + 1);

   state_type    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [SW-1:0] sweep_ff, sweep_in;
   logic [6:0]    rd_pos_ff, rd_pos_in;
   rsp_item_type  rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   cmd_type       cmd;
   logic [CW-1:0] fill_lim;
   logic          req_accept;
   logic [XW-1:0] pos_x, cnt_x, cnt_next_x;

   logic [63:0]   word_q [DEPTH];
   logic [63:0]   col_q  [DEPTH];

   // ---------------------------------------------------------------
   // cell row
   // ---------------------------------------------------------------
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [63:0] left_w, right_w, col_r;
      if (g == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = word_q[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign right_w = word_q[g];
         assign col_r   = '0;
      end else begin : g_mid_r
         assign right_w = word_q[g+1];
         assign col_r   = col_q[g+1];
      end

      ieil_cell #(
         .DEPTH (DEPTH),
         .INDEX (g)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cnt        (cnt_ff),
         .fill_lim   (fill_lim),
         .rd_pos     (rd_pos_ff),
         .word_left  (left_w),
         .word_right (right_w),
         .col_right  (col_r),
         .word_q     (word_q[g]),
         .col_q      (col_q[g])
      );
   end

   // ---------------------------------------------------------------
   // control
   // ---------------------------------------------------------------
   assign req_ready  = (state_ff == S_RUN) && (!rsp_valid_ff || rsp_ready);
   assign req_accept = req_valid && req_ready;

   assign pos_x      = XW'(req_data.position);
   assign cnt_x      = XW'(cnt_ff);
   assign cnt_next_x = XW'(cnt_in);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      sweep_in     = sweep_ff;
      rd_pos_in    = rd_pos_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.action   = ACT_HOLD;
      cmd.pos      = req_data.position;
      cmd.word     = req_data.word_in;
      fill_lim     = cnt_ff;

      unique case (state_ff)
         S_RUN: begin
            if (req_accept) begin
               rsp_in.word_out = '0;
               rsp_in.status   = STAT_OK;
               unique case (req_data.req_type)
                  OP_APPEND: begin
                     if (cnt_ff == CW'(DEPTH)) begin
                        rsp_in.status = STAT_FULL;
                     end else begin
                        cmd.action = ACT_FILL;
                        fill_lim   = cnt_ff + 1'b1;
                        cnt_in     = cnt_ff + 1'b1;
                     end
                  end
                  OP_DROP: begin
                     if (cnt_ff != '0) cnt_in = cnt_ff - 1'b1;
                  end
                  OP_INSERT: begin
                     if (pos_x > cnt_x) begin
                        rsp_in.status = STAT_RANGE;
                     end else if (cnt_ff == CW'(DEPTH)) begin
                        rsp_in.status = STAT_FULL;
                     end else begin
                        cmd.action = ACT_INSERT;
                        cnt_in     = cnt_ff + 1'b1;
                     end
                  end
                  OP_ERASE: begin
                     if (pos_x >= cnt_x) begin
                        rsp_in.status = STAT_RANGE;
                     end else begin
                        cmd.action = ACT_ERASE;
                        cnt_in     = cnt_ff - 1'b1;
                     end
                  end
                  OP_READ: begin
                     if (pos_x >= cnt_x) begin
                        rsp_in.status = STAT_RANGE;
                     end else begin
                        // start the collector sweep
                        state_in  = S_SWEEP;
                        sweep_in  = SW'(DEPTH);
                        rd_pos_in = req_data.position;
                     end
                  end
                  OP_WRITE: begin
                     if (pos_x >= cnt_x) rsp_in.status = STAT_RANGE;
                     else cmd.action = ACT_WRITE;
                  end
                  OP_CLEAR: begin
                     cnt_in = '0;
                  end
                  OP_RESIZE: begin
                     if (pos_x > XW'(DEPTH)) begin
                        rsp_in.status = STAT_FULL;
                     end else begin
                        // new slots between old and new length get the fill word
                        cmd.action = ACT_FILL;
                        fill_lim   = CW'(pos_x);
                        cnt_in     = CW'(pos_x);
                     end
                  end
                  default: rsp_in.status = STAT_OK;
               endcase
               rsp_in.length   = cnt_next_x[6:0];
               rsp_in.is_empty = (cnt_in == '0);
               rsp_valid_in    = (state_in == S_RUN);
            end
         end
         S_SWEEP: begin
            // once the sweep counter has run down to zero the addressed word sits in cell 0
            if (sweep_ff == '0) begin
               state_in        = S_RUN;
               rsp_in.word_out = col_q[0];
               rsp_in.status   = STAT_OK;
               rsp_in.length   = cnt_x[6:0];
               rsp_in.is_empty = (cnt_ff == '0);
               rsp_valid_in    = 1'b1;
            end else begin
               sweep_in = sweep_ff - 1'b1;
            end
         end
         default: state_in = S_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RUN;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sweep_ff  <= sweep_in;
      rd_pos_ff <= rd_pos_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
